>>> rtl/tmt64_pkg.sv
// shared constants, types and codes for the tinymt64 generator
package tmt64_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    localparam logic [WORD_W-1:0] LOW63_MASK = 64'h7fff_ffff_ffff_ffff;
    localparam logic [WORD_W-1:0] INIT_MULT  = 64'd6364136223846793005;
    localparam logic [HALF_W-1:0] MAT1_RESET = 32'hfa05_1f40;
    localparam logic [HALF_W-1:0] MAT2_RESET = 32'hffd0_fff4;
    localparam logic [WORD_W-1:0] TMAT_RESET = 64'h58d0_2ffe_ffbf_ffbc;
    localparam logic [WORD_W-1:0] CERT_LOW   = 64'd84;
    localparam logic [WORD_W-1:0] CERT_HIGH  = 64'd77;

    localparam int unsigned SHIFT_A      = 12;
    localparam int unsigned SHIFT_B      = 11;
    localparam int unsigned TEMPER_SHIFT = 8;
    localparam int unsigned INIT_ROUNDS  = 8;
    localparam int unsigned ROUND_W      = $clog2(INIT_ROUNDS);

    localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(1);
    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(INIT_ROUNDS - 1);

    // operation codes
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    // register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TMAT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_PREP,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_WAIT,
        ST_SEED_UPD,
        ST_SEED_CERT,
        ST_GEN_STEP,
        ST_GEN_OUT
    } state_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
        logic shift;
    } mac_ctl_t;

endpackage

>>> rtl/tmt64_mac.sv
// shared 32x32 multiplier with 64-bit accumulator, one product per cycle
module tmt64_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tmt64_pkg::mac_ctl_t                 ctl,
    input  logic [tmt64_pkg::HALF_W-1:0]        op_a,
    input  logic [tmt64_pkg::HALF_W-1:0]        op_b,
    output logic [tmt64_pkg::WORD_W-1:0]        acc
);

    tmt64_pkg::mac_ctl_t                 ctl_reg;
    logic [tmt64_pkg::WORD_W-1:0]        prod_reg;
    logic [tmt64_pkg::WORD_W-1:0]        acc_reg;
    logic [tmt64_pkg::WORD_W-1:0]        acc_next;
    logic [tmt64_pkg::WORD_W-1:0]        base;
    logic [tmt64_pkg::WORD_W-1:0]        addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= tmt64_pkg::WORD_W'(op_a) * tmt64_pkg::WORD_W'(op_b);
        acc_reg  <= acc_next;
    end

    always_comb begin
        base     = ctl_reg.first ? '0 : acc_reg;
        addend   = ctl_reg.shift ? {prod_reg[tmt64_pkg::HALF_W-1:0], {tmt64_pkg::HALF_W{1'b0}}}
                                 : prod_reg;
        acc_next = ctl_reg.issue ? base + addend : acc_reg;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/tinymt64_random_generator.sv
// top level: tinymt64 generator with sequencer, state and parameter registers
//
// A generate request (opcode 1) is taken when s_ready is high; the block runs the
// xorshift step, then registers the tempered value onto the m_ channel, waiting
// while an earlier value is held, and takes no new request until it is idle again.
// A seed request (opcode 0) gives no result and keeps the block busy for seven
// initialisation rounds, each preparing the operand, issuing three partial products
// to the single 32x32 multiplier that forms the 64-bit product, waiting and updating
// the state, then a period certification step. The user must write parameter
// registers on the cfg_ channel only while the block is idle; the block does not
// enforce this. Index 0 mat1, 1 mat2, 2 tempering mask; other indexes are ignored.
module tinymt64_random_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [tmt64_pkg::WORD_W-1:0]          s_seed_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tmt64_pkg::WORD_W-1:0]          m_random_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tmt64_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmt64_pkg::WORD_W-1:0]          cfg_data
);

    tmt64_pkg::state_t                   state_reg, state_next;
    logic [tmt64_pkg::WORD_W-1:0]        low_reg, low_next;
    logic [tmt64_pkg::WORD_W-1:0]        high_reg, high_next;
    logic [tmt64_pkg::HALF_W-1:0]        mat1_reg;
    logic [tmt64_pkg::HALF_W-1:0]        mat2_reg;
    logic [tmt64_pkg::WORD_W-1:0]        tmat_reg;
    logic [tmt64_pkg::ROUND_W-1:0]       round_reg, round_next;
    logic [tmt64_pkg::WORD_W-1:0]        p_reg, p_next;
    logic                                m_valid_reg, m_valid_next;
    logic [tmt64_pkg::WORD_W-1:0]        m_value_reg, m_value_next;

    tmt64_pkg::mac_ctl_t                 mac_ctl;
    logic [tmt64_pkg::HALF_W-1:0]        mac_a;
    logic [tmt64_pkg::HALF_W-1:0]        mac_b;
    logic [tmt64_pkg::WORD_W-1:0]        mac_acc;

    logic                                s_fire;
    logic                                cfg_fire;
    logic [tmt64_pkg::WORD_W-1:0]        prev;
    logic [tmt64_pkg::WORD_W-1:0]        round_sum;
    logic [tmt64_pkg::WORD_W-1:0]        x;
    logic [tmt64_pkg::WORD_W-1:0]        t;

    tmt64_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (mac_acc)
    );

    assign s_ready        = (state_reg == tmt64_pkg::ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign cfg_ready      = 1'b1;
    assign cfg_fire       = cfg_valid && cfg_ready;
    assign m_valid        = m_valid_reg;
    assign m_random_value = m_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmt64_pkg::ST_IDLE;
            round_reg   <= tmt64_pkg::FIRST_ROUND;
            m_valid_reg <= 1'b0;
            low_reg     <= tmt64_pkg::CERT_LOW;
            high_reg    <= tmt64_pkg::CERT_HIGH;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        m_value_reg <= m_value_next;
    end

    // parameter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat1_reg <= tmt64_pkg::MAT1_RESET;
            mat2_reg <= tmt64_pkg::MAT2_RESET;
            tmat_reg <= tmt64_pkg::TMAT_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                tmt64_pkg::CFG_MAT1: mat1_reg <= cfg_data[tmt64_pkg::HALF_W-1:0];
                tmt64_pkg::CFG_MAT2: mat2_reg <= cfg_data[tmt64_pkg::HALF_W-1:0];
                tmt64_pkg::CFG_TMAT: tmat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        round_next   = round_reg;
        p_next       = p_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        mac_ctl      = '0;
        mac_a        = p_reg[tmt64_pkg::HALF_W-1:0];
        mac_b        = tmt64_pkg::INIT_MULT[tmt64_pkg::HALF_W-1:0];

        // odd round reads the low word and updates the high word
        prev      = round_reg[0] ? low_reg : high_reg;
        round_sum = mac_acc + tmt64_pkg::WORD_W'(round_reg);

        // xorshift step
        x = (low_reg & tmt64_pkg::LOW63_MASK) ^ high_reg;
        x = x ^ (x << tmt64_pkg::SHIFT_A);
        x = x ^ (x >> tmt64_pkg::HALF_W);
        x = x ^ (x << tmt64_pkg::HALF_W);
        x = x ^ (x << tmt64_pkg::SHIFT_B);

        // tempering
        t = low_reg + high_reg;
        t = t ^ (low_reg >> tmt64_pkg::TEMPER_SHIFT);
        if (t[0]) begin
            t = t ^ tmat_reg;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            tmt64_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == tmt64_pkg::OP_SEED) begin
                        low_next   = s_seed_value ^ {mat1_reg, {tmt64_pkg::HALF_W{1'b0}}};
                        high_next  = tmt64_pkg::WORD_W'(mat2_reg) ^ tmat_reg;
                        round_next = tmt64_pkg::FIRST_ROUND;
                        state_next = tmt64_pkg::ST_SEED_PREP;
                    end else begin
                        state_next = tmt64_pkg::ST_GEN_STEP;
                    end
                end
            end
            tmt64_pkg::ST_SEED_PREP: begin
                p_next     = prev ^ (prev >> 62);
                state_next = tmt64_pkg::ST_MUL_LL;
            end
            tmt64_pkg::ST_MUL_LL: begin
                mac_ctl    = '{issue: 1'b1, first: 1'b1, shift: 1'b0};
                state_next = tmt64_pkg::ST_MUL_LH;
            end
            tmt64_pkg::ST_MUL_LH: begin
                mac_ctl    = '{issue: 1'b1, first: 1'b0, shift: 1'b1};
                mac_b      = tmt64_pkg::INIT_MULT[tmt64_pkg::WORD_W-1:tmt64_pkg::HALF_W];
                state_next = tmt64_pkg::ST_MUL_HL;
            end
            tmt64_pkg::ST_MUL_HL: begin
                mac_ctl    = '{issue: 1'b1, first: 1'b0, shift: 1'b1};
                mac_a      = p_reg[tmt64_pkg::WORD_W-1:tmt64_pkg::HALF_W];
                state_next = tmt64_pkg::ST_MUL_WAIT;
            end
            tmt64_pkg::ST_MUL_WAIT: begin
                state_next = tmt64_pkg::ST_SEED_UPD;
            end
            tmt64_pkg::ST_SEED_UPD: begin
                if (round_reg[0]) begin
                    high_next = high_reg ^ round_sum;
                end else begin
                    low_next = low_reg ^ round_sum;
                end
                if (round_reg == tmt64_pkg::LAST_ROUND) begin
                    state_next = tmt64_pkg::ST_SEED_CERT;
                end else begin
                    round_next = round_reg + 1'b1;
                    state_next = tmt64_pkg::ST_SEED_PREP;
                end
            end
            tmt64_pkg::ST_SEED_CERT: begin
                if (((low_reg & tmt64_pkg::LOW63_MASK) == '0) && (high_reg == '0)) begin
                    low_next  = tmt64_pkg::CERT_LOW;
                    high_next = tmt64_pkg::CERT_HIGH;
                end
                state_next = tmt64_pkg::ST_IDLE;
            end
            tmt64_pkg::ST_GEN_STEP: begin
                low_next   = high_reg ^ (x[0] ? tmt64_pkg::WORD_W'(mat1_reg) : '0);
                high_next  = x ^ (x[0] ? {mat2_reg, {tmt64_pkg::HALF_W{1'b0}}} : '0);
                state_next = tmt64_pkg::ST_GEN_OUT;
            end
            tmt64_pkg::ST_GEN_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = t;
                    state_next   = tmt64_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tmt64_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tmt64_checker.sv
// port-level checks for the tinymt64 generator, bound to the top level
module tmt64_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [tmt64_pkg::WORD_W-1:0]          m_random_value
);

    // no result pending straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value))
        else $error("held result changed");

    // every accepted request makes the block busy, dropping s_ready
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken on consecutive cycles");

    // a seed request taken with no result pending yields none straight after
    a_seed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == tmt64_pkg::OP_SEED) && !m_valid
        |=> !m_valid ##1 !m_valid)
        else $error("result after seed request");

endmodule

bind tinymt64_random_generator tmt64_checker u_tmt64_checker (.*);
